### rtl/sga_pkg.sv
// Shared types and constants for the SQL group aggregation block.
`timescale 1ns / 1ps

package sga_pkg;

	// Aggregate modes held in the configuration register
	localparam logic [2:0] MODE_COUNT   = 3'd0;
	localparam logic [2:0] MODE_SUM     = 3'd1;
	localparam logic [2:0] MODE_AVERAGE = 3'd2;
	localparam logic [2:0] MODE_MINIMUM = 3'd3;
	localparam logic [2:0] MODE_MAXIMUM = 3'd4;

	// Request opcodes
	localparam logic OP_ACCUMULATE = 1'b0;
	localparam logic OP_FINISH     = 1'b1;

	// Error codes
	localparam logic [1:0] ERR_NONE      = 2'd0;
	localparam logic [1:0] ERR_COUNT_OVF = 2'd1;
	localparam logic [1:0] ERR_SUM_OVF   = 2'd2;

	// Width of the integer part of the average dividend
	localparam int VALUE_W = 64;

	// Largest row count the 63-bit counter holds (the largest signed 64-bit value)
	localparam logic [62:0] ROW_TOTAL_MAX = {63{1'b1}};

	// Commands from the controller to the datapath
	typedef struct packed {
		logic acc;       // accumulate the request's row
		logic fin;       // finish the group: emit directly or start the divider
		logic div_step;  // one restoring division step
		logic div_load;  // move the divider result into the output register
	} sga_cmd_t;

	// Status from the datapath to the controller
	typedef struct packed {
		logic need_div;  // finish now would need the average divider
	} sga_status_t;

endpackage

### rtl/sga_ctrl.sv
// Controller state machine: handshakes, divider sequencing and output valid.
`timescale 1ns / 1ps

module sga_ctrl #(
	parameter int QW = 80
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic                opcode,
	output logic                out_valid,
	input  logic                out_ready,
	input  sga_pkg::sga_status_t status,
	output sga_pkg::sga_cmd_t   cmd
);
	import sga_pkg::*;

	localparam int CW = $clog2(QW);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_DIV  = 2'd1;
	localparam logic [1:0] ST_DONE = 2'd2;

	logic [1:0]    state_q;
	logic [CW-1:0] step_q;
	logic          out_valid_q;
	logic          fin_ok;
	logic          acc_fire;
	logic          fin_fire;
	logic          last_step;
	logic          load_direct;

	// Rows always flow; a finish waits for a free divider and output slot
	assign fin_ok    = (state_q == ST_IDLE) && (!out_valid_q || out_ready);
	assign in_ready  = (opcode == OP_ACCUMULATE) || fin_ok;
	assign acc_fire  = in_valid && in_ready && (opcode == OP_ACCUMULATE);
	assign fin_fire  = in_valid && in_ready && (opcode == OP_FINISH);
	assign last_step = (step_q == CW'(QW - 1));

	assign load_direct = fin_fire && !status.need_div;

	always_comb begin
		cmd.acc      = acc_fire;
		cmd.fin      = fin_fire;
		cmd.div_step = (state_q == ST_DIV);
		cmd.div_load = (state_q == ST_DONE);
	end

	// Sequence the divider
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q  <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (fin_fire && status.need_div) begin
						state_q <= ST_DIV;
						step_q  <= '0;
					end
				end
				ST_DIV: begin
					if (last_step) begin
						state_q <= ST_DONE;
					end else begin
						step_q <= step_q + CW'(1);
					end
				end
				ST_DONE: begin
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Hold the result valid until it is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_direct || cmd.div_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;

endmodule

### rtl/sga_dpath.sv
// Datapath: group accumulators, bit-serial average divider and output register.
`timescale 1ns / 1ps

module sga_dpath #(
	parameter int FRACTION_BITS = 16,
	parameter int QW            = 80
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [2:0]           cfg_wdata,
	input  sga_pkg::sga_cmd_t    cmd,
	output sga_pkg::sga_status_t status,
	input  logic signed [63:0]   row_value,
	input  logic                 row_is_null,
	output logic signed [63:0]   result_value,
	output logic [15:0]          average_fraction,
	output logic                 result_is_null,
	output logic [1:0]           error_status
);
	import sga_pkg::*;

	localparam logic [15:0] FRAC_MASK = (FRACTION_BITS >= 16) ? 16'hFFFF :
		16'((32'd1 << FRACTION_BITS) - 32'd1);

	// Configuration and group state
	logic [2:0]         mode_q;
	logic [62:0]        row_total_q;
	logic signed [63:0] running_sum_q;
	logic signed [63:0] extremum_q;
	logic               ext_valid_q;
	logic [1:0]         sticky_q;

	// Divider state
	logic [QW-1:0]      dq_q;
	logic [62:0]        rem_q;
	logic [62:0]        dvs_q;
	logic               neg_q;
	logic [1:0]         div_err_q;

	// Output register
	logic signed [63:0] res_value_q;
	logic [15:0]        res_frac_q;
	logic               res_null_q;
	logic [1:0]         res_err_q;

	logic [2:0]         eff_mode;
	logic               take_row;
	logic signed [63:0] sum_next;
	logic               sum_ovf;
	logic               take_ext;
	logic               is_sum_mode;
	logic               is_ext_mode;
	logic [63:0]        sum_mag;
	logic [63:0]        trial;
	logic               trial_ge;
	logic [63:0]        trial_diff;
	logic [QW-1:0]      div_shift;
	logic [63:0]        quotient;
	logic signed [63:0] direct_value;
	logic               direct_null;

	// Undefined modes act as count
	assign eff_mode    = (mode_q > MODE_MAXIMUM) ? MODE_COUNT : mode_q;
	assign is_sum_mode = (eff_mode == MODE_SUM) || (eff_mode == MODE_AVERAGE);
	assign is_ext_mode = (eff_mode == MODE_MINIMUM) || (eff_mode == MODE_MAXIMUM);

	assign status.need_div = (eff_mode == MODE_AVERAGE) && (row_total_q != '0);

	// Checked add and extremum compare
	assign take_row = cmd.acc && !row_is_null && (sticky_q == ERR_NONE);
	assign sum_next = running_sum_q + row_value;
	assign sum_ovf  = (running_sum_q[63] == row_value[63]) && (sum_next[63] != row_value[63]);
	assign take_ext = !ext_valid_q ||
		((eff_mode == MODE_MINIMUM) ? (row_value < extremum_q) : (row_value > extremum_q));

	// Direct result for every finish that skips the divider
	always_comb begin
		direct_value = '0;
		direct_null  = 1'b0;
		if (eff_mode == MODE_COUNT) begin
			direct_value = signed'({1'b0, row_total_q});
		end else if (row_total_q == '0) begin
			direct_null = 1'b1;
		end else if (eff_mode == MODE_SUM) begin
			direct_value = running_sum_q;
		end else if (ext_valid_q) begin
			direct_value = extremum_q;
		end
	end

	// Write the mode register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_COUNT;
		end else if (cfg_we) begin
			mode_q <= cfg_wdata;
		end
	end

	// Accumulate rows; clear the group on finish
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_total_q   <= '0;
			running_sum_q <= '0;
			extremum_q    <= '0;
			ext_valid_q   <= 1'b0;
			sticky_q      <= ERR_NONE;
		end else if (cmd.fin) begin
			row_total_q   <= '0;
			running_sum_q <= '0;
			extremum_q    <= '0;
			ext_valid_q   <= 1'b0;
			sticky_q      <= ERR_NONE;
		end else if (take_row) begin
			if (row_total_q == ROW_TOTAL_MAX) begin
				sticky_q <= ERR_COUNT_OVF;
			end else begin
				row_total_q <= row_total_q + 63'd1;
				if (is_sum_mode) begin
					if (sum_ovf) begin
						sticky_q <= ERR_SUM_OVF;
					end else begin
						running_sum_q <= sum_next;
					end
				end else if (is_ext_mode && take_ext) begin
					extremum_q  <= row_value;
					ext_valid_q <= 1'b1;
				end
			end
		end
	end

	// Restoring division step on the magnitude shifted by the fraction bits
	assign sum_mag    = running_sum_q[63] ? (64'd0 - 64'(running_sum_q)) : 64'(running_sum_q);
	assign trial      = {rem_q, dq_q[QW-1]};
	assign trial_ge   = (trial >= {1'b0, dvs_q});
	assign trial_diff = trial - {1'b0, dvs_q};
	assign div_shift  = dq_q >> FRACTION_BITS;
	assign quotient   = div_shift[63:0];

	always_ff @(posedge clk) begin
		if (cmd.fin && status.need_div) begin
			dq_q      <= QW'(sum_mag) << FRACTION_BITS;
			rem_q     <= '0;
			dvs_q     <= row_total_q;
			neg_q     <= running_sum_q[63];
			div_err_q <= sticky_q;
		end else if (cmd.div_step) begin
			dq_q  <= {dq_q[QW-2:0], trial_ge};
			rem_q <= trial_ge ? trial_diff[62:0] : trial[62:0];
		end
	end

	// Load the output register from the direct path or the divider
	always_ff @(posedge clk) begin
		if (cmd.fin && !status.need_div) begin
			res_value_q <= direct_value;
			res_frac_q  <= '0;
			res_null_q  <= direct_null;
			res_err_q   <= sticky_q;
		end else if (cmd.div_load) begin
			res_value_q <= signed'(neg_q ? (64'd0 - quotient) : quotient);
			res_frac_q  <= dq_q[15:0] & FRAC_MASK;
			res_null_q  <= 1'b0;
			res_err_q   <= div_err_q;
		end
	end

	assign result_value     = res_value_q;
	assign average_fraction = res_frac_q;
	assign result_is_null   = res_null_q;
	assign error_status     = res_err_q;

endmodule

### rtl/sql_group_aggregate.sv
// Top level of the SQL group aggregation block.
//
//  channel   direction  handshake             payload
//  config    in         cfg_we                cfg_wdata (aggregate_mode)
//  request   in         in_valid / in_ready   opcode, row_value, row_is_null
//  result    out        out_valid / out_ready result_value, average_fraction,
//                                             result_is_null, error_status
//
// An accumulate request is always accepted, one per cycle.
// A finish in count, sum, minimum or maximum mode, or in average mode on an empty
// group, shows its result the next cycle. Otherwise an average finish runs the
// bit-serial divider: 64 + FRACTION_BITS steps and then a load into the result
// register; rows of the next group are accepted meanwhile, another finish waits.
// A finish is held while a result waits; reset clears all group state at once.
`timescale 1ns / 1ps

module sql_group_aggregate #(
	parameter int FRACTION_BITS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [2:0]         cfg_wdata,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               opcode,
	input  logic signed [63:0] row_value,
	input  logic               row_is_null,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [63:0] result_value,
	output logic [15:0]        average_fraction,
	output logic               result_is_null,
	output logic [1:0]         error_status
);
	import sga_pkg::*;

	localparam int QW = VALUE_W + FRACTION_BITS;

	sga_cmd_t    cmd;
	sga_status_t status;

	sga_ctrl #(
		.QW(QW)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.opcode    (opcode),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.status    (status),
		.cmd       (cmd)
	);

	sga_dpath #(
		.FRACTION_BITS(FRACTION_BITS),
		.QW           (QW)
	) u_dpath (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_we           (cfg_we),
		.cfg_wdata        (cfg_wdata),
		.cmd              (cmd),
		.status           (status),
		.row_value        (row_value),
		.row_is_null      (row_is_null),
		.result_value     (result_value),
		.average_fraction (average_fraction),
		.result_is_null   (result_is_null),
		.error_status     (error_status)
	);

endmodule

### rtl/sga_check.sv
// Port checker for the SQL group aggregation block and its bind.
`timescale 1ns / 1ps

module sga_check (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_ready,
	input logic               opcode,
	input logic               out_valid,
	input logic               out_ready,
	input logic signed [63:0] result_value,
	input logic [15:0]        average_fraction,
	input logic               result_is_null,
	input logic [1:0]         error_status
);
	import sga_pkg::*;

	// Hold a stalled result
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(result_value) &&
		$stable(average_fraction) && $stable(result_is_null) && $stable(error_status))
		else $error("stalled result changed");

	// Null results carry zero value and fraction
	a_null_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && result_is_null |-> result_value == 64'sd0 && average_fraction == 16'd0)
		else $error("null result with nonzero payload");

	// Only defined error codes appear
	a_err_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> error_status == ERR_NONE || error_status == ERR_COUNT_OVF ||
		error_status == ERR_SUM_OVF)
		else $error("undefined error code");

	// Row requests never stall
	a_rows_flow: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && opcode == OP_ACCUMULATE |-> in_ready)
		else $error("accumulate request stalled");

endmodule

bind sql_group_aggregate sga_check u_sga_check (
	.clk              (clk),
	.arst_n           (arst_n),
	.in_valid         (in_valid),
	.in_ready         (in_ready),
	.opcode           (opcode),
	.out_valid        (out_valid),
	.out_ready        (out_ready),
	.result_value     (result_value),
	.average_fraction (average_fraction),
	.result_is_null   (result_is_null),
	.error_status     (error_status)
);

### dv/sql_group_aggregate_test.sv
// Testbench for sql_group_aggregate: directed table plus random groups, checked by a predictor.
`timescale 1ns / 1ps

module sql_group_aggregate_test;
	import sga_pkg::*;

	localparam int FRAC_BITS = 16;
	// Divider latency of an average finish plus margin
	localparam int SETTLE_CYCLES = 70 + FRAC_BITS + 10;
	localparam int RANDOM_ITEMS = 700;
	localparam int LONG_HOLD = 400;
	localparam int PRESSURE_PHASE = 8;
	localparam longint TIMEOUT_NS = 2_000_000;

	localparam logic signed [63:0] I64_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
	localparam logic signed [63:0] I64_MIN = 64'sh8000_0000_0000_0000;

	// Register values with no mode of their own; the block treats them as count
	localparam logic [2:0] MODE_RSVD5 = 3'd5;
	localparam logic [2:0] MODE_RSVD6 = 3'd6;
	localparam logic [2:0] MODE_RSVD7 = 3'd7;
	localparam logic [23:0] LEAD_MODES = {MODE_RSVD6, MODE_RSVD5, MODE_RSVD7, MODE_MAXIMUM,
		MODE_MINIMUM, MODE_AVERAGE, MODE_SUM, MODE_COUNT};

	typedef struct packed {
		logic signed [63:0] value;
		logic [15:0]        fraction;
		logic               is_null;
		logic [1:0]         err;
	} agg_result_t;

	typedef struct {
		logic [2:0]         mode;
		logic               op;
		logic signed [63:0] val;
		logic               nul;
		logic               typed;
		agg_result_t        want;
	} plan_row_t;

	logic               clk;
	logic               arst_n;
	logic               cfg_we;
	logic [2:0]         cfg_wdata;
	logic               in_valid;
	logic               in_ready;
	logic               opcode;
	logic signed [63:0] row_value;
	logic               row_is_null;
	logic               out_valid;
	logic               out_ready;
	logic signed [63:0] result_value;
	logic [15:0]        average_fraction;
	logic               result_is_null;
	logic [1:0]         error_status;

	sql_group_aggregate #(.FRACTION_BITS(FRAC_BITS)) dut (.*);

	// Predicted group state
	logic [2:0]         mode_reg;
	logic [62:0]        rows_seen;
	logic signed [63:0] sum_acc;
	logic signed [63:0] extreme;
	logic               extreme_ok;
	logic [1:0]         err_latch;

	agg_result_t group_results_due[$];
	plan_row_t   plan_rows[$];
	int          mismatches = 0;
	logic        hold_request = 1'b0;
	logic        sink_steady = 1'b0;
	logic        sender_steady = 1'b0;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#(TIMEOUT_NS);
		$display("** sql_group_aggregate: FAILED **");
		$finish;
	end

	function automatic logic [2:0] active_mode();
		return (mode_reg > MODE_MAXIMUM) ? MODE_COUNT : mode_reg;
	endfunction

	// Fold one non-null row into the open group
	function automatic void fold_row(input logic signed [63:0] v);
		logic [2:0]  m;
		logic [64:0] wide;
		m = active_mode();
		if (err_latch != ERR_NONE)
			return;
		if (rows_seen == ROW_TOTAL_MAX) begin
			err_latch = ERR_COUNT_OVF;
			return;
		end
		rows_seen++;
		if (m == MODE_SUM || m == MODE_AVERAGE) begin
			wide = {sum_acc[63], sum_acc} + {v[63], v};
			// drop the row when the sign of the 65-bit sum disagrees with bit 63
			if (wide[64] != wide[63]) begin
				err_latch = ERR_SUM_OVF;
				return;
			end
			sum_acc = wide[63:0];
		end else if (m == MODE_MINIMUM || m == MODE_MAXIMUM) begin
			if (!extreme_ok || (m == MODE_MINIMUM ? v < extreme : v > extreme)) begin
				extreme = v;
				extreme_ok = 1'b1;
			end
		end
	endfunction

	// Emit the group's result and clear the group
	function automatic agg_result_t close_group();
		agg_result_t r;
		logic [2:0]  m;
		logic [63:0] mag;
		logic [63:0] quo;
		logic [63:0] rem;
		logic [79:0] scaled;
		r = '0;
		m = active_mode();
		if (m == MODE_COUNT) begin
			r.value = {1'b0, rows_seen};
		end else if (rows_seen == 0) begin
			r.is_null = 1'b1;
		end else if (m == MODE_SUM) begin
			r.value = sum_acc;
		end else if (m == MODE_AVERAGE) begin
			mag = sum_acc[63] ? 64'd0 - sum_acc : sum_acc;
			quo = mag / {1'b0, rows_seen};
			rem = mag % {1'b0, rows_seen};
			scaled = ({16'd0, rem} << FRAC_BITS) / {17'd0, rows_seen};
			r.fraction = scaled[15:0];
			r.value = sum_acc[63] ? 64'd0 - quo : quo;
		end else begin
			r.value = extreme_ok ? extreme : 64'sd0;
		end
		r.err = err_latch;
		rows_seen = '0;
		sum_acc = '0;
		extreme = '0;
		extreme_ok = 1'b0;
		err_latch = ERR_NONE;
		return r;
	endfunction

	// Mostly short gaps, now and then a long one
	function automatic int unsigned pick_gap();
		return ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60) : $urandom_range(1, 3);
	endfunction

	function automatic logic signed [63:0] pick_row_value();
		logic signed [63:0] v;
		case ($urandom_range(0, 9))
			0, 1, 2, 3: v = longint'($urandom_range(0, 2000)) - 64'sd1000;
			4: v = longint'($urandom_range(0, 3));
			5, 6: v = {$urandom, $urandom};
			7: v = $urandom_range(0, 1) ? I64_MAX - longint'($urandom_range(0, 3))
				: I64_MIN + longint'($urandom_range(0, 3));
			default: v = $signed({$urandom, $urandom}) >>> 2;
		endcase
		return v;
	endfunction

	function automatic void add_step(input logic [2:0] m, input logic op,
			input logic signed [63:0] v, input logic nul, input logic typed,
			input agg_result_t want);
		plan_row_t row;
		row.mode = m;
		row.op = op;
		row.val = v;
		row.nul = nul;
		row.typed = typed;
		row.want = want;
		plan_rows.push_back(row);
	endfunction

	// Offer one request, hold it until accepted, then update the prediction
	task automatic send_request(input logic op, input logic signed [63:0] v, input logic nul,
			input logic typed, input agg_result_t want);
		agg_result_t predicted;
		in_valid <= 1'b1;
		opcode <= op;
		row_value <= v;
		row_is_null <= nul;
		do @(posedge clk); while (!in_ready);
		if (op == OP_ACCUMULATE) begin
			if (!nul)
				fold_row(v);
		end else begin
			predicted = close_group();
			group_results_due.push_back(typed ? want : predicted);
		end
	endtask

	task automatic sender_pause();
		int unsigned g;
		g = (sender_steady || $urandom_range(0, 2) != 0) ? 0 : pick_gap();
		if (g != 0) begin
			in_valid <= 1'b0;
			repeat (g) @(posedge clk);
		end
	endtask

	// Drain all results, let the divider settle, then write the mode
	task automatic set_mode(input logic [2:0] m);
		in_valid <= 1'b0;
		while (group_results_due.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= m;
		@(posedge clk);
		cfg_we <= 1'b0;
		mode_reg = m;
	endtask

	task automatic check_result();
		agg_result_t want;
		if (group_results_due.size() == 0) begin
			$error("result with none outstanding: result_value %0d", result_value);
			mismatches++;
		end else begin
			want = group_results_due.pop_front();
			if (result_value !== want.value) begin
				$error("result_value: expected %0d, got %0d", want.value, result_value);
				mismatches++;
			end
			if (average_fraction !== want.fraction) begin
				$error("average_fraction: expected %0d, got %0d", want.fraction,
					average_fraction);
				mismatches++;
			end
			if (result_is_null !== want.is_null) begin
				$error("result_is_null: expected %0d, got %0d", want.is_null, result_is_null);
				mismatches++;
			end
			if (error_status !== want.err) begin
				$error("error_status: expected %0d, got %0d", want.err, error_status);
				mismatches++;
			end
		end
	endtask

	// Result side: check each accepted result and stall at random
	initial begin : result_sink
		int unsigned hold_left;
		int unsigned cyc;
		hold_left = 0;
		cyc = 0;
		out_ready <= 1'b0;
		do @(posedge clk); while (!arst_n);
		forever begin
			@(posedge clk);
			cyc++;
			if (out_valid && out_ready)
				check_result();
			if (cyc % 256 == 0)
				sink_steady = ($urandom_range(0, 3) == 0);
			if (hold_left == 0) begin
				if (hold_request) begin
					hold_request = 1'b0;
					hold_left = LONG_HOLD;
				end else if (!sink_steady && $urandom_range(0, 3) == 0) begin
					hold_left = pick_gap();
				end
			end
			if (hold_left != 0) begin
				out_ready <= 1'b0;
				hold_left--;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// Request side: directed table, then random groups
	initial begin : request_source
		int sent;
		int phase;
		int groups;
		int rows;
		mode_reg = MODE_COUNT;
		rows_seen = '0;
		sum_acc = '0;
		extreme = '0;
		extreme_ok = 1'b0;
		err_latch = ERR_NONE;

		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_wdata <= MODE_COUNT;
		in_valid <= 1'b0;
		opcode <= OP_ACCUMULATE;
		row_value <= '0;
		row_is_null <= 1'b0;

		// empty groups, sum overflow both ways, average rounding, extremes, null rows,
		// mode change inside a group, undefined mode acting as count
		add_step(MODE_COUNT, OP_FINISH, 64'sd0, 1'b0, 1'b1, {64'sd0, 16'd0, 1'b0, ERR_NONE});
		add_step(MODE_SUM, OP_FINISH, 64'sd0, 1'b0, 1'b1, {64'sd0, 16'd0, 1'b1, ERR_NONE});
		add_step(MODE_SUM, OP_ACCUMULATE, I64_MAX, 1'b0, 1'b0, '0);
		add_step(MODE_SUM, OP_ACCUMULATE, 64'sd1, 1'b0, 1'b0, '0);
		add_step(MODE_SUM, OP_ACCUMULATE, 64'sd5, 1'b0, 1'b0, '0);
		add_step(MODE_SUM, OP_FINISH, 64'sd0, 1'b0, 1'b1, {I64_MAX, 16'd0, 1'b0, ERR_SUM_OVF});
		add_step(MODE_SUM, OP_ACCUMULATE, I64_MIN, 1'b0, 1'b0, '0);
		add_step(MODE_SUM, OP_ACCUMULATE, -64'sd1, 1'b0, 1'b0, '0);
		add_step(MODE_SUM, OP_FINISH, -64'sd1, 1'b1, 1'b1, {I64_MIN, 16'd0, 1'b0, ERR_SUM_OVF});
		add_step(MODE_AVERAGE, OP_ACCUMULATE, -64'sd7, 1'b0, 1'b0, '0);
		add_step(MODE_AVERAGE, OP_ACCUMULATE, 64'sd100, 1'b1, 1'b0, '0);
		add_step(MODE_AVERAGE, OP_ACCUMULATE, 64'sd0, 1'b0, 1'b0, '0);
		add_step(MODE_AVERAGE, OP_FINISH, I64_MAX, 1'b0, 1'b1,
			{-64'sd3, 16'd32768, 1'b0, ERR_NONE});
		add_step(MODE_AVERAGE, OP_ACCUMULATE, I64_MIN, 1'b0, 1'b0, '0);
		add_step(MODE_AVERAGE, OP_FINISH, 64'sd0, 1'b0, 1'b1, {I64_MIN, 16'd0, 1'b0, ERR_NONE});
		add_step(MODE_MINIMUM, OP_ACCUMULATE, 64'sd5, 1'b0, 1'b0, '0);
		add_step(MODE_MINIMUM, OP_ACCUMULATE, I64_MAX, 1'b0, 1'b0, '0);
		add_step(MODE_MINIMUM, OP_ACCUMULATE, I64_MIN, 1'b1, 1'b0, '0);
		add_step(MODE_MINIMUM, OP_FINISH, 64'sd0, 1'b0, 1'b1, {64'sd5, 16'd0, 1'b0, ERR_NONE});
		add_step(MODE_MAXIMUM, OP_ACCUMULATE, I64_MIN, 1'b0, 1'b0, '0);
		add_step(MODE_MAXIMUM, OP_FINISH, 64'sd0, 1'b0, 1'b1, {I64_MIN, 16'd0, 1'b0, ERR_NONE});
		add_step(MODE_MAXIMUM, OP_ACCUMULATE, 64'sd3, 1'b0, 1'b0, '0);
		add_step(MODE_SUM, OP_ACCUMULATE, 64'sd10, 1'b0, 1'b0, '0);
		add_step(MODE_RSVD7, OP_ACCUMULATE, 64'sd1, 1'b0, 1'b0, '0);
		add_step(MODE_RSVD7, OP_FINISH, 64'sd0, 1'b0, 1'b1, {64'sd3, 16'd0, 1'b0, ERR_NONE});

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// walk the table
		foreach (plan_rows[i]) begin
			if (plan_rows[i].mode != mode_reg)
				set_mode(plan_rows[i].mode);
			send_request(plan_rows[i].op, plan_rows[i].val, plan_rows[i].nul,
				plan_rows[i].typed, plan_rows[i].want);
			sender_pause();
		end

		// random phases: one mode write, then a few groups
		sent = 0;
		phase = 0;
		while (sent < RANDOM_ITEMS) begin
			set_mode(phase < 8 ? LEAD_MODES[phase * 3 +: 3] : 3'($urandom_range(0, 7)));
			sender_steady = (phase == PRESSURE_PHASE) || ($urandom_range(0, 4) == 0);
			// stall the result side while back-to-back finishes pile up
			if (phase == PRESSURE_PHASE)
				hold_request = 1'b1;
			groups = (phase == PRESSURE_PHASE) ? 8 : $urandom_range(1, 4);
			for (int g = 0; g < groups; g++) begin
				if (phase == PRESSURE_PHASE)
					rows = $urandom_range(0, 2);
				else
					rows = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
						: $urandom_range(0, 6);
				for (int r = 0; r < rows; r++) begin
					send_request(OP_ACCUMULATE, pick_row_value(), $urandom_range(0, 9) == 0,
						1'b0, '0);
					sender_pause();
					sent++;
				end
				// leave the last group open now and then so the next mode picks it up
				if (g != groups - 1 || $urandom_range(0, 4) != 0) begin
					send_request(OP_FINISH, {$urandom, $urandom}, 1'($urandom_range(0, 1)),
						1'b0, '0);
					sender_pause();
					sent++;
				end
			end
			phase++;
		end

		// drain and report
		in_valid <= 1'b0;
		while (group_results_due.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("** sql_group_aggregate: PASSED **");
		else
			$display("** sql_group_aggregate: FAILED **");
		$finish;
	end

endmodule
